### sv/text_mode_cell_rasterizer_macros.svh
// Assertion macros for the text mode cell rasterizer checker.
// No dependencies; included by the checker file only.
`ifndef TEXT_MODE_CELL_RASTERIZER_MACROS_SVH
`define TEXT_MODE_CELL_RASTERIZER_MACROS_SVH

// Same-cycle implication, held off while reset is asserted
`define TMCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcr checker: same-cycle rule broken");

// Next-cycle implication, held off while reset is asserted
`define TMCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmcr checker: next-cycle rule broken");

`endif

### sv/tmcr_pkg.sv
// Shared types, constants and colour functions for the text mode cell rasterizer.
// No dependencies; scoped names in the top level and checker, imported by the testbench.
`default_nettype none

package tmcr_pkg;

    // Default sizes of the character cell and the font
    localparam int CELL_ROWS_DEF   = 16;
    localparam int GLYPH_COUNT_DEF = 256;

    localparam int COLOUR_W    = 24;
    localparam int CFG_INDEX_W = 1;

    // Request kinds
    typedef enum logic [1:0] {
        ACT_RENDER   = 2'd0,
        ACT_FONT_WR  = 2'd1,
        ACT_PAL_WR   = 2'd2
    } action_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FONT_SELECT   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GUEST_PALETTE = 1'd1;

    // Stored colours are 0x00bbggrr; the pixel stream wants 0x00rrggbb
    function automatic logic [COLOUR_W-1:0] swap_to_rgb(input logic [COLOUR_W-1:0] c);
        return {c[7:0], c[15:8], c[23:16]};
    endfunction

    // Fixed sixteen colour CGA table, held as 0x00bbggrr
    function automatic logic [COLOUR_W-1:0] cga_bgr(input logic [3:0] idx);
        logic [COLOUR_W-1:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'hAA0000;
            4'd2:    c = 24'h00AA00;
            4'd3:    c = 24'hAAAA00;
            4'd4:    c = 24'h0000AA;
            4'd5:    c = 24'hAA00AA;
            4'd6:    c = 24'h0055AA;
            4'd7:    c = 24'hAAAAAA;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'hFF5555;
            4'd10:   c = 24'h55FF55;
            4'd11:   c = 24'hFFFF55;
            4'd12:   c = 24'h5555FF;
            4'd13:   c = 24'hFF55FF;
            4'd14:   c = 24'h55FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/tmcr_cell_if.sv
// Request channel carrying one cell scanline render or a font/palette write.
// Depends on nothing beyond plain logic types.
`default_nettype none

interface tmcr_cell_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  character;
    logic [7:0]  attribute;
    logic [3:0]  scan_line;
    logic        font_bank;
    logic [3:0]  palette_slot;
    logic [23:0] write_data;

    modport source (
        output valid, action, character, attribute, scan_line,
               font_bank, palette_slot, write_data,
        input  ready
    );

    modport sink (
        input  valid, action, character, attribute, scan_line,
               font_bank, palette_slot, write_data,
        output ready
    );
endinterface

`default_nettype wire

### sv/tmcr_pix_if.sv
// Result channel carrying eight 0x00rrggbb pixels, pixel_0 leftmost.
// Depends on nothing beyond plain logic types.
`default_nettype none

interface tmcr_pix_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_0;
    logic [23:0] pixel_1;
    logic [23:0] pixel_2;
    logic [23:0] pixel_3;
    logic [23:0] pixel_4;
    logic [23:0] pixel_5;
    logic [23:0] pixel_6;
    logic [23:0] pixel_7;

    modport source (
        output valid, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7,
        input  ready
    );

    modport sink (
        input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
               pixel_4, pixel_5, pixel_6, pixel_7,
        output ready
    );
endinterface

`default_nettype wire

### sv/tmcr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tmcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/text_mode_cell_rasterizer.sv
// Top level of the text mode cell rasterizer: font and palette memories, render pipeline.
// Depends on tmcr_pkg, tmcr_cell_if, tmcr_pix_if and tmcr_ram.
//
//  Channel   Direction  Carries
//  cells     in         render request or font / palette write request
//  pixels    out        eight 24-bit pixels for each render request
//  cfg_*     in         register write: font select enable, guest palette
//
// One request is taken every cycle unless the input stalls. A render request passes the
// font and palette memory reads, then colour selection into the output register, before
// its pixels show. Write requests land in memory at the edge they are taken (font writes
// only for scanlines inside the cell), so the next request already reads them.
// Input stalls only when both the read stage and the output register are full
// and the output is held. No clearing pass after reset.
`default_nettype none

module text_mode_cell_rasterizer #(
    parameter int CELL_ROWS   = tmcr_pkg::CELL_ROWS_DEF,
    parameter int GLYPH_COUNT = tmcr_pkg::GLYPH_COUNT_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [tmcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic                             cfg_data,
    tmcr_cell_if.sink                             cells,
    tmcr_pix_if.source                            pixels
);

    localparam int FONT_BYTES = GLYPH_COUNT * CELL_ROWS;
    localparam int ROW_AW     = $clog2(FONT_BYTES);
    // each bank spans the full power-of-two range of the glyph offset
    localparam int FONT_AW    = ROW_AW + 1;
    localparam int FONT_DEPTH = 2 ** FONT_AW;
    localparam int CW         = tmcr_pkg::COLOUR_W;
    localparam logic [5:0] ROWS_L = 6'(CELL_ROWS);

    // Configuration registers
    logic font_sel_reg, font_sel_next;
    logic guest_pal_reg, guest_pal_next;

    // Read stage
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_in_cell_reg;
    logic [3:0] s1_fg_idx_reg;
    logic [3:0] s1_bg_idx_reg;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] pixel_reg  [8];
    logic [CW-1:0] pixel_next [8];

    logic              accept;
    logic              s1_advance;
    logic              in_cell;
    logic              bank_sel;
    logic [ROW_AW-1:0] glyph_offset;
    logic [FONT_AW-1:0] font_addr;
    logic              font_wr_en;
    logic              render_rd;
    logic              pal_wr_en;
    logic [7:0]        font_rd;
    logic [CW-1:0]     pal_fg_rd;
    logic [CW-1:0]     pal_bg_rd;
    logic [7:0]        glyph;
    logic [CW-1:0]     fg_colour;
    logic [CW-1:0]     bg_colour;

    // Handshake
    assign s1_advance  = !out_valid_reg || pixels.ready;
    assign cells.ready = !s1_valid_reg || s1_advance;
    assign accept      = cells.valid && cells.ready;

    // Font address: bank on top, then character * rows + scanline
    assign in_cell      = {2'b00, cells.scan_line} < ROWS_L;
    assign glyph_offset = ROW_AW'(ROW_AW'(cells.character) * ROW_AW'(CELL_ROWS)
                                  + ROW_AW'(cells.scan_line));
    assign bank_sel     = (cells.action == tmcr_pkg::ACT_RENDER)
                          ? (font_sel_reg && cells.attribute[3]) : cells.font_bank;
    assign font_addr    = {bank_sel, glyph_offset};

    assign render_rd  = accept && (cells.action == tmcr_pkg::ACT_RENDER);
    assign font_wr_en = accept && (cells.action == tmcr_pkg::ACT_FONT_WR) && in_cell;
    assign pal_wr_en  = accept && (cells.action == tmcr_pkg::ACT_PAL_WR);

    // Both font banks in one memory
    tmcr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font_ram (
        .clk     (clk),
        .wr_en   (font_wr_en),
        .wr_addr (font_addr),
        .wr_data (cells.write_data[7:0]),
        .rd_en   (render_rd),
        .rd_addr (font_addr),
        .rd_data (font_rd)
    );

    // Palette held twice so foreground and background read together
    tmcr_ram #(
        .WIDTH (CW),
        .DEPTH (16)
    ) u_pal_fg_ram (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (cells.palette_slot),
        .wr_data (cells.write_data),
        .rd_en   (render_rd),
        .rd_addr (cells.attribute[3:0]),
        .rd_data (pal_fg_rd)
    );

    tmcr_ram #(
        .WIDTH (CW),
        .DEPTH (16)
    ) u_pal_bg_ram (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (cells.palette_slot),
        .wr_data (cells.write_data),
        .rd_en   (render_rd),
        .rd_addr (cells.attribute[7:4]),
        .rd_data (pal_bg_rd)
    );

    // Configuration writes
    always_comb
    begin
        font_sel_next  = font_sel_reg;
        guest_pal_next = guest_pal_reg;
        if (cfg_wen)
        begin
            case (cfg_index)
                tmcr_pkg::CFG_FONT_SELECT:   font_sel_next  = cfg_data;
                tmcr_pkg::CFG_GUEST_PALETTE: guest_pal_next = cfg_data;
                default:                     ;
            endcase
        end
    end

    // Stage occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (render_rd)
        begin
            s1_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && s1_advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Colour selection; scanline outside the cell shows background only
    always_comb
    begin
        glyph     = s1_in_cell_reg ? font_rd : 8'h00;
        fg_colour = tmcr_pkg::swap_to_rgb(guest_pal_reg ? pal_fg_rd
                                          : tmcr_pkg::cga_bgr(s1_fg_idx_reg));
        bg_colour = tmcr_pkg::swap_to_rgb(guest_pal_reg ? pal_bg_rd
                                          : tmcr_pkg::cga_bgr(s1_bg_idx_reg));
        for (int k = 0; k < 8; k++)
        begin
            pixel_next[k] = glyph[7-k] ? fg_colour : bg_colour;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_sel_reg  <= 1'b0;
            guest_pal_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            font_sel_reg  <= font_sel_next;
            guest_pal_reg <= guest_pal_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (render_rd)
        begin
            s1_in_cell_reg <= in_cell;
            s1_fg_idx_reg  <= cells.attribute[3:0];
            s1_bg_idx_reg  <= cells.attribute[7:4];
        end
        if (s1_valid_reg && s1_advance)
        begin
            pixel_reg <= pixel_next;
        end
    end

    assign pixels.valid   = out_valid_reg;
    assign pixels.pixel_0 = pixel_reg[0];
    assign pixels.pixel_1 = pixel_reg[1];
    assign pixels.pixel_2 = pixel_reg[2];
    assign pixels.pixel_3 = pixel_reg[3];
    assign pixels.pixel_4 = pixel_reg[4];
    assign pixels.pixel_5 = pixel_reg[5];
    assign pixels.pixel_6 = pixel_reg[6];
    assign pixels.pixel_7 = pixel_reg[7];

endmodule

`default_nettype wire

### sv/tmcr_checker.sv
// Port-level checker for the text mode cell rasterizer, bound to the top level.
// Depends on tmcr_pkg and text_mode_cell_rasterizer_macros.svh.
`default_nettype none
`include "text_mode_cell_rasterizer_macros.svh"

module tmcr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [1:0]  in_action,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] out_pixel_0,
    input wire logic [23:0] out_pixel_7
);

    logic render_req;

    assign render_req = in_valid && in_ready && (in_action == tmcr_pkg::ACT_RENDER);

    // A held result stays valid and keeps pixels 0 and 7
    `TMCR_ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel_0) && $stable(out_pixel_7))

    // A result that newly turns valid always traces back to an earlier render request
    `TMCR_ASSERT_NOW(a_result_has_source, clk, rst_n, $rose(out_valid), $past(render_req, 2))

    // A render request taken into an empty output shows up after the read stage and output register
    `TMCR_ASSERT_NEXT(a_render_lands, clk, rst_n, render_req && !out_valid, ##1 out_valid)

    // Input back-pressure only comes from a held result
    `TMCR_ASSERT_NOW(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready)

endmodule

bind text_mode_cell_rasterizer tmcr_checker u_tmcr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cells.valid),
    .in_ready    (cells.ready),
    .in_action   (cells.action),
    .out_valid   (pixels.valid),
    .out_ready   (pixels.ready),
    .out_pixel_0 (pixels.pixel_0),
    .out_pixel_7 (pixels.pixel_7)
);

`default_nettype wire

### tb/sv/tb.sv
// Testbench for text_mode_cell_rasterizer: a directed plan, then random requests under several
// register settings, every pixel row checked against a local scanline predictor.
// Depends on text_mode_cell_rasterizer, tmcr_pkg, tmcr_cell_if and tmcr_pix_if from the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcr_pkg::*;

    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;    // two-stage pipe plus margin
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int PLAN_LEN     = 20;

    // Action code the block must ignore
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Fixed text palette as it leaves the block, 0x00rrggbb
    localparam logic [23:0] CGA_RGB [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct {
        logic [1:0]  act;
        logic [7:0]  chr;
        logic [7:0]  attr;
        logic [3:0]  scan;
        logic        bank;
        logic [3:0]  slot;
        logic [23:0] data;
    } cell_req_t;

    // Eight pixels, index 0 leftmost
    typedef logic [7:0][23:0] scanline_t;

    typedef enum {STEP_REQUEST, STEP_SOLID, STEP_REG} step_kind_t;

    typedef struct {
        step_kind_t              kind;
        cell_req_t               req;
        logic [23:0]             solid;     // whole row in this colour
        logic [CFG_INDEX_W-1:0]  reg_idx;
        logic                    reg_val;
    } plan_step_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wen;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic                   cfg_data;

    tmcr_cell_if cells();
    tmcr_pix_if  pixels();

    text_mode_cell_rasterizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells),
        .pixels    (pixels)
    );

    // Predictor state: fonts, palette, registers, and the rows still to come out
    logic [7:0]  glyph_rom [2][4096];
    bit          glyph_known [2][4096];
    logic [23:0] palette_bgr [16];
    bit          palette_known [16];
    bit          font_sel_en;
    bit          guest_pal_en;
    scanline_t   pixel_q [$];

    int errors = 0;
    int cycle_count = 0;
    int stall_left = 0;
    int stall_pct = 10;
    int gap_pct = 10;
    int requests_done = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Colour index to 0x00rrggbb under the current palette setting
    function automatic logic [23:0] colour_rgb(input logic [3:0] idx);
        logic [23:0] c;
        if (guest_pal_en)
        begin
            c = palette_bgr[idx];
            return {c[7:0], c[15:8], c[23:16]};
        end
        return CGA_RGB[idx];
    endfunction

    // Expected pixel row for a render request
    function automatic scanline_t rasterise(input cell_req_t r);
        bit          sec;
        logic [7:0]  glyph;
        logic [23:0] fg;
        logic [23:0] bg;
        scanline_t   row;
        sec   = font_sel_en && r.attr[3];
        glyph = glyph_rom[sec][{r.chr, r.scan}];
        fg    = colour_rgb(r.attr[3:0]);
        bg    = colour_rgb(r.attr[7:4]);
        for (int k = 0; k < 8; k++)
            row[k] = glyph[7 - k] ? fg : bg;
        return row;
    endfunction

    // Apply one accepted request to the predictor
    task automatic account(input cell_req_t r, input bit typed, input logic [23:0] solid);
        case (r.act)
            ACT_FONT_WR:
            begin
                glyph_rom[r.bank][{r.chr, r.scan}]   = r.data[7:0];
                glyph_known[r.bank][{r.chr, r.scan}] = 1'b1;
            end
            ACT_PAL_WR:
            begin
                palette_bgr[r.slot]   = r.data;
                palette_known[r.slot] = 1'b1;
            end
            ACT_RENDER:
                pixel_q.push_back(typed ? {8{solid}} : rasterise(r));
            default: ;
        endcase
    endtask

    // Offer one request, wait for it to be taken, then maybe leave a gap
    task automatic send_request(input cell_req_t r, input bit typed = 1'b0,
                                input logic [23:0] solid = '0);
        int gap;
        cells.valid        <= 1'b1;
        cells.action       <= r.act;
        cells.character    <= r.chr;
        cells.attribute    <= r.attr;
        cells.scan_line    <= r.scan;
        cells.font_bank    <= r.bank;
        cells.palette_slot <= r.slot;
        cells.write_data   <= r.data;
        @(posedge clk);
        while (!cells.ready)
            @(posedge clk);
        account(r, typed, solid);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 14);
            cells.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write, only once the pipe has emptied
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        cells.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == CFG_FONT_SELECT)
            font_sel_en = val;
        else
            guest_pal_en = val;
    endtask

    // One random request; a render first loads any glyph byte or palette entry it reads
    task automatic random_request();
        cell_req_t   r;
        cell_req_t   pre;
        int          roll;
        bit          sec;
        logic [3:0]  nib;
        r.act  = ACT_RENDER;
        r.chr  = 8'($urandom_range(0, 255));
        r.attr = 8'($urandom_range(0, 255));
        r.scan = 4'($urandom_range(0, 15));
        r.bank = 1'($urandom_range(0, 1));
        r.slot = 4'($urandom_range(0, 15));
        r.data = 24'($urandom_range(0, 24'hFFFFFF));
        roll   = $urandom_range(0, 99);
        if (roll < 4)
        begin
            r.act = ACT_UNUSED;
            send_request(r);
            return;
        end
        if (roll < 22)
            r.act = ACT_FONT_WR;
        else if (roll < 32)
            r.act = ACT_PAL_WR;
        else
        begin
            // half the renders revisit a small set of glyphs
            if ($urandom_range(0, 1) == 1)
                r.chr = 8'($urandom_range(0, 15));
            sec = font_sel_en && r.attr[3];
            if (!glyph_known[sec][{r.chr, r.scan}])
            begin
                pre      = r;
                pre.act  = ACT_FONT_WR;
                pre.bank = sec;
                pre.data = 24'($urandom_range(0, 24'hFFFFFF));
                send_request(pre);
                requests_done++;
            end
            if (guest_pal_en)
                for (int i = 0; i < 2; i++)
                begin
                    nib = (i == 0) ? r.attr[3:0] : r.attr[7:4];
                    if (!palette_known[nib])
                    begin
                        pre      = r;
                        pre.act  = ACT_PAL_WR;
                        pre.slot = nib;
                        pre.data = 24'($urandom_range(0, 24'hFFFFFF));
                        send_request(pre);
                        requests_done++;
                    end
                end
        end
        send_request(r);
        requests_done++;
    endtask

    // Output back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left   <= stall_left - 1;
            pixels.ready <= 1'b0;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left   <= $urandom_range(0, 13);
            pixels.ready <= 1'b0;
        end
        else
            pixels.ready <= 1'b1;
    end

    // Compare each pixel row taken with the oldest expected row
    always @(posedge clk)
    begin
        scanline_t got;
        scanline_t want;
        if (rst_n && pixels.valid && pixels.ready)
        begin
            got = {pixels.pixel_7, pixels.pixel_6, pixels.pixel_5, pixels.pixel_4,
                   pixels.pixel_3, pixels.pixel_2, pixels.pixel_1, pixels.pixel_0};
            if (pixel_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel row, expected none, got %h", $time, got);
            end
            else
            begin
                want = pixel_q.pop_front();
                for (int k = 0; k < 8; k++)
                    if (got[k] !== want[k])
                    begin
                        errors++;
                        $display("%0t: pixel_%0d expected %06h got %06h",
                                 $time, k, want[k], got[k]);
                    end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        plan_step_t plan [PLAN_LEN];
        bit [1:0]   setting [PHASES];   // bit 0 font select, bit 1 guest palette

        rst_n              = 1'b0;
        cfg_wen            = 1'b0;
        cfg_index          = '0;
        cfg_data           = 1'b0;
        cells.valid        = 1'b0;
        cells.action       = ACT_RENDER;
        cells.character    = '0;
        cells.attribute    = '0;
        cells.scan_line    = '0;
        cells.font_bank    = 1'b0;
        cells.palette_slot = '0;
        cells.write_data   = '0;
        pixels.ready       = 1'b0;
        font_sel_en        = 1'b0;
        guest_pal_en       = 1'b0;

        // Directed plan: extremes, both fonts, both palettes, ignored action
        plan = '{
            '{STEP_REQUEST, '{ACT_FONT_WR, 8'h00, 8'h00, 4'h0, 1'b0, 4'h0, 24'hFFFFFF},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_SOLID,   '{ACT_RENDER,  8'h00, 8'h0F, 4'h0, 1'b0, 4'h0, 24'h000000},
              24'hFFFFFF, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_FONT_WR, 8'hFF, 8'h00, 4'hF, 1'b0, 4'h0, 24'hFFFF00},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_SOLID,   '{ACT_RENDER,  8'hFF, 8'h10, 4'hF, 1'b0, 4'h0, 24'h000000},
              24'h0000AA, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_FONT_WR, 8'h41, 8'h00, 4'h7, 1'b0, 4'h0, 24'h0000A5},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_RENDER,  8'h41, 8'h4E, 4'h7, 1'b0, 4'h0, 24'h000000},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_FONT_WR, 8'h41, 8'h00, 4'h7, 1'b1, 4'h0, 24'hFF005A},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_UNUSED,  8'hFF, 8'hFF, 4'hF, 1'b1, 4'hF, 24'hFFFFFF},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_RENDER,  8'h41, 8'h08, 4'h7, 1'b0, 4'h0, 24'h000000},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REG,     '{ACT_RENDER,  8'h00, 8'h00, 4'h0, 1'b0, 4'h0, 24'h000000},
              24'h0, CFG_FONT_SELECT, 1'b1},
            '{STEP_REQUEST, '{ACT_RENDER,  8'h41, 8'h08, 4'h7, 1'b0, 4'h0, 24'h000000},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_RENDER,  8'h41, 8'h77, 4'h7, 1'b1, 4'hF, 24'hFFFFFF},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REG,     '{ACT_RENDER,  8'h00, 8'h00, 4'h0, 1'b0, 4'h0, 24'h000000},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_PAL_WR,  8'h00, 8'h00, 4'h0, 1'b0, 4'h0, 24'h123456},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REQUEST, '{ACT_PAL_WR,  8'h00, 8'h00, 4'h0, 1'b0, 4'hF, 24'hFFFFFF},
              24'h0, CFG_FONT_SELECT, 1'b0},
            '{STEP_REG,     '{ACT_RENDER,  8'h00, 8'h00, 4'h0, 1'b0, 4'h0, 24'h000000},
              24'h0, CFG_GUEST_PALETTE, 1'b1},
            '{STEP_SOLID,   '{ACT_RENDER,  8'h00, 8'h0F, 4'h0, 1'b0, 4'h0, 24'h000000},
              24'hFFFFFF, CFG_FONT_SELECT, 1'b0},
            '{STEP_SOLID,   '{ACT_RENDER,  8'hFF, 8'h0F, 4'hF, 1'b0, 4'h0, 24'h000000},
              24'h563412, CFG_FONT_SELECT, 1'b0},
            '{STEP_SOLID,   '{ACT_RENDER,  8'hFF, 8'hF0, 4'hF, 1'b0, 4'h0, 24'h000000},
              24'hFFFFFF, CFG_FONT_SELECT, 1'b0},
            '{STEP_REG,     '{ACT_RENDER,  8'h00, 8'h00, 4'h0, 1'b0, 4'h0, 24'h000000},
              24'h0, CFG_GUEST_PALETTE, 1'b0}
        };

        // Register settings per random phase; the last phase runs without idling
        setting[0] = 2'b11;
        setting[1] = 2'b10;
        setting[2] = 2'b01;
        setting[3] = 2'($urandom_range(0, 3));
        setting[4] = 2'b00;
        setting[5] = 2'($urandom_range(0, 3));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++)
            case (plan[i].kind)
                STEP_REG:   write_register(plan[i].reg_idx, plan[i].reg_val);
                STEP_SOLID: send_request(plan[i].req, 1'b1, plan[i].solid);
                default:    send_request(plan[i].req);
            endcase

        for (int p = 0; p < PHASES; p++)
        begin
            write_register(CFG_FONT_SELECT, setting[p][0]);
            write_register(CFG_GUEST_PALETTE, setting[p][1]);
            if (p == PHASES - 1)
            begin
                gap_pct    = 0;
                stall_pct <= 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 10;
                    default: stall_pct <= 35;
                endcase
            end
            requests_done = 0;
            while (requests_done < PHASE_ITEMS)
                random_request();
        end

        // Let the last rows come out
        cells.valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
